// ===== hw/rtl/timer_table_earliest_expiry_unit_defines.svh =====
// Assertion macros shared by the timer table RTL.
`ifndef TIMER_TABLE_EARLIEST_EXPIRY_UNIT_DEFINES_SVH
`define TIMER_TABLE_EARLIEST_EXPIRY_UNIT_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define TTE_ASSERT_HOLDS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("timer table assertion failed");

// A condition that must hold in the same cycle as its trigger.
`define TTE_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("timer table assertion failed");

// A condition that must hold in the cycle after its trigger.
`define TTE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("timer table assertion failed");

`endif

// ===== hw/rtl/tte_pkg.sv =====
package tte_pkg;

   localparam int MAX_TIMERS = 32;

   localparam logic [1:0] MODE_SCHEDULE   = 2'd0;
   localparam logic [1:0] MODE_CANCEL     = 2'd1;
   localparam logic [1:0] MODE_RESCHEDULE = 2'd2;
   localparam logic [1:0] MODE_QUERY      = 2'd3;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND  = 2'd1;
   localparam logic [1:0] STATUS_TABLE_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [47:0]        now_time;
      logic signed [31:0] delay;
      logic signed [31:0] target_id;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] new_timer_id;
      logic               expired;
      logic               armed;
      logic [47:0]        earliest_expiry;
   } rsp_type;

   // The token that walks the row of cells, one cell per cycle.
   typedef struct packed {
      logic        active;
      logic [1:0]  mode;
      logic [47:0] now_time;
      logic [47:0] expiry;
      logic [31:0] target_id;
      logic [30:0] new_id;
      logic        placed;
      logic        found;
      logic        expired;
      logic        armed;
      logic [47:0] min_expiry;
   } token_type;

endpackage

// ===== hw/rtl/tte_cell.sv =====
module tte_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  tte_pkg::token_type   tok_in,
   output tte_pkg::token_type   tok_out
);

   logic               valid_ff;
   logic               valid_in;
   logic [30:0]        id_ff;
   logic [30:0]        id_in;
   logic [47:0]        expiry_ff;
   logic [47:0]        expiry_in;
   tte_pkg::token_type tok_ff;
   tte_pkg::token_type tok_next_in;

   logic match;
   logic removes;
   logic schedules;
   logic place;

   always_comb begin
      match = tok_in.active && valid_ff && !tok_in.found && !tok_in.target_id[31]
              && (id_ff == tok_in.target_id[30:0]) && (tok_in.mode != tte_pkg::MODE_SCHEDULE);
      removes   = (tok_in.mode == tte_pkg::MODE_CANCEL) ||
                  (tok_in.mode == tte_pkg::MODE_RESCHEDULE);
      schedules = (tok_in.mode == tte_pkg::MODE_SCHEDULE) ||
                  (tok_in.mode == tte_pkg::MODE_RESCHEDULE);
      // The cancel step sees the old contents; a slot it frees may take the new timer.
      place = tok_in.active && schedules && !tok_in.placed
              && (!valid_ff || (match && removes));

      valid_in  = valid_ff;
      id_in     = id_ff;
      expiry_in = expiry_ff;
      if (place) begin
         valid_in  = 1'b1;
         id_in     = tok_in.new_id;
         expiry_in = tok_in.expiry;
      end else if (match && removes) begin
         valid_in = 1'b0;
      end

      tok_next_in = tok_in;
      if (match) begin
         tok_next_in.found = 1'b1;
         if (tok_in.mode == tte_pkg::MODE_QUERY) begin
            tok_next_in.expired = tok_in.now_time > expiry_ff;
         end
      end
      if (place) begin
         tok_next_in.placed = 1'b1;
      end
      // Running minimum over the contents this cell holds after the request.
      if (tok_in.active && valid_in) begin
         if (!tok_in.armed || (expiry_in < tok_in.min_expiry)) begin
            tok_next_in.min_expiry = expiry_in;
         end
         tok_next_in.armed = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (tok_in.active) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_in.active) begin
         id_ff     <= id_in;
         expiry_ff <= expiry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff <= tok_next_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ===== hw/rtl/timer_table_earliest_expiry_unit.sv =====
// A word accepted at one edge walks the row of MAX_TIMERS registered cells, one cell a cycle,
// and its result is formed as the token leaves the last cell. No new word is taken until
// the last one is through: busy stays high until the result strobe has passed.
// Results cannot be stalled: rsp_strobe is high for exactly one cycle per word.
// Synchronous active-high reset clears all valid bits, the id counter and busy.
`include "timer_table_earliest_expiry_unit_defines.svh"

module timer_table_earliest_expiry_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tte_pkg::req_type req_data,
   output logic             rsp_strobe,
   output tte_pkg::rsp_type rsp_data
);

   // The timer table is spread over a row of cells, each holding one entry.
   // A request becomes a token that enters the first cell and moves one cell
   // per cycle. Each cell looks up the id, removes or stores an entry as the
   // mode asks, and folds its final contents into the running minimum. The
   // lowest-index rules of the table fall out of the walk order: the first
   // matching cell claims the id, the first free cell claims the new timer.

   tte_pkg::token_type tok_chain [0:tte_pkg::MAX_TIMERS];
   tte_pkg::token_type tok_head;
   tte_pkg::token_type tok_last;

   logic        busy_ff;
   logic        busy_in;
   logic [30:0] id_counter_ff;
   logic [30:0] id_counter_in;
   logic        accept;
   logic [48:0] expiry_sum;
   logic [tte_pkg::MAX_TIMERS-1:0] active_vec;
   logic        schedules;

   assign accept = start && !busy_ff;

   // Negative delays count as zero; the sum saturates at the top of the time range.
   always_comb begin
      expiry_sum = {1'b0, req_data.now_time}
                 + {18'b0, (req_data.delay[31] ? 31'd0 : req_data.delay[30:0])};

      tok_head            = '0;
      tok_head.active     = accept;
      tok_head.mode       = req_data.mode;
      tok_head.now_time   = req_data.now_time;
      tok_head.expiry     = expiry_sum[48] ? {48{1'b1}} : expiry_sum[47:0];
      tok_head.target_id  = req_data.target_id;
      tok_head.new_id     = id_counter_ff;
   end

   assign tok_chain[0] = tok_head;

   genvar gi;
   generate
      for (gi = 0; gi < tte_pkg::MAX_TIMERS; gi++) begin : g_cell
         tte_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .tok_in  (tok_chain[gi]),
            .tok_out (tok_chain[gi+1])
         );
         assign active_vec[gi] = tok_chain[gi+1].active;
      end
   endgenerate

   assign tok_last = tok_chain[tte_pkg::MAX_TIMERS];

   // The result word is formed straight from the token leaving the last cell.
   always_comb begin
      schedules = (tok_last.mode == tte_pkg::MODE_SCHEDULE) ||
                  (tok_last.mode == tte_pkg::MODE_RESCHEDULE);

      rsp_data = '0;
      if (schedules) begin
         rsp_data.status = tok_last.placed ? tte_pkg::STATUS_OK : tte_pkg::STATUS_TABLE_FULL;
      end else begin
         rsp_data.status = tok_last.found ? tte_pkg::STATUS_OK : tte_pkg::STATUS_NOT_FOUND;
      end
      rsp_data.new_timer_id = (schedules && tok_last.placed) ? $signed({1'b0, tok_last.new_id})
                                                             : -32'sd1;
      rsp_data.expired = (tok_last.mode == tte_pkg::MODE_QUERY) && tok_last.found
                         && tok_last.expired;
      rsp_data.armed   = tok_last.armed;
      if (!tok_last.armed) begin
         rsp_data.earliest_expiry = 48'd0;
      end else if (tok_last.min_expiry == 48'd0) begin
         rsp_data.earliest_expiry = 48'd1;
      end else begin
         rsp_data.earliest_expiry = tok_last.min_expiry;
      end
   end

   assign rsp_strobe = tok_last.active;
   assign busy       = busy_ff;

   // The id counter moves on only when a new timer was actually stored.
   always_comb begin
      id_counter_in = id_counter_ff;
      if (tok_last.active && schedules && tok_last.placed) begin
         id_counter_in = id_counter_ff + 31'd1;
      end
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (tok_last.active) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         id_counter_ff <= 31'd0;
      end else begin
         busy_ff       <= busy_in;
         id_counter_ff <= id_counter_in;
      end
   end

   // Only one request may be walking the row at any time.
   `TTE_ASSERT_HOLDS(a_one_token, $onehot0(active_vec))
   // A result only appears while its request is still marked in flight.
   `TTE_ASSERT_SAME(a_strobe_busy, rsp_strobe, busy_ff)
   // An accepted word keeps the block busy in the next cycle.
   `TTE_ASSERT_NEXT(a_accept_busy, accept, busy_ff)
   // The strobe never lasts longer than one cycle.
   `TTE_ASSERT_NEXT(a_strobe_single, rsp_strobe, !rsp_strobe)
   // An armed table always reports a nonzero earliest expiry.
   `TTE_ASSERT_SAME(a_armed_floor, rsp_strobe && rsp_data.armed,
                    rsp_data.earliest_expiry != 48'd0)

endmodule

// ===== sim/timer_table_earliest_expiry_unit_tb.sv =====
`timescale 1ns / 100ps

module timer_table_earliest_expiry_unit_tb;

   // A word walks the whole row inside the block, and the sender may idle before a word.
   // A stretch without any handshake that reaches STALL_LIMIT means the block hung.
   localparam int STALL_LIMIT  = 1000;
   localparam int RANDOM_WORDS = 525;
   // Quiet time after the last result, a little longer than the walk of a token through the row.
   localparam int SETTLE_CYCLES = 40;

   // Keeps its own copy of the timer table. For every accepted request word it works
   // out the answer the block must give, and it compares each answer as it arrives.
   class timer_table_tracker;
      logic             slot_used   [tte_pkg::MAX_TIMERS];
      logic [30:0]      slot_id     [tte_pkg::MAX_TIMERS];
      logic [47:0]      slot_expiry [tte_pkg::MAX_TIMERS];
      logic [30:0]      next_id;
      tte_pkg::rsp_type pending_answers [$];
      int               mismatches;
      int               mode_seen [4];
      int               full_seen;
      int               missing_seen;
      int               expired_seen;
      int               peak_used;

      function new();
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         foreach (mode_seen[i]) mode_seen[i] = 0;
         next_id      = '0;
         mismatches   = 0;
         full_seen    = 0;
         missing_seen = 0;
         expired_seen = 0;
         peak_used    = 0;
      endfunction

      // Lowest valid slot holding the id; a negative id never matches.
      function int find_slot(input logic [31:0] id);
         int hit;
         hit = -1;
         if (!id[31]) begin
            for (int i = tte_pkg::MAX_TIMERS - 1; i >= 0; i--) begin
               if (slot_used[i] && slot_id[i] == id[30:0]) hit = i;
            end
         end
         return hit;
      endfunction

      // Arms a timer in the lowest free slot. The expiry saturates at the top of the
      // 48-bit range, and a full table leaves the table and the id counter alone.
      function logic [1:0] place_timer(input logic [47:0] now, input logic [31:0] dly,
                                       output logic [31:0] nid);
         logic [48:0] sum;
         int          slot;
         slot = -1;
         nid  = '1;
         sum  = {1'b0, now} + (dly[31] ? 49'd0 : {17'd0, dly});
         if (sum[48]) sum[47:0] = '1;
         for (int i = tte_pkg::MAX_TIMERS - 1; i >= 0; i--) begin
            if (!slot_used[i]) slot = i;
         end
         if (slot < 0) return tte_pkg::STATUS_TABLE_FULL;
         slot_used[slot]   = 1'b1;
         slot_id[slot]     = next_id;
         slot_expiry[slot] = sum[47:0];
         nid               = {1'b0, next_id};
         next_id           = next_id + 31'd1;
         return tte_pkg::STATUS_OK;
      endfunction

      function tte_pkg::rsp_type compute_answer(input tte_pkg::req_type w);
         tte_pkg::rsp_type ans;
         int               s;
         int               used;
         logic [31:0]      nid;
         ans  = '0;
         nid  = '1;
         used = 0;
         case (w.mode)
            tte_pkg::MODE_SCHEDULE: begin
               ans.status = place_timer(w.now_time, w.delay, nid);
            end
            tte_pkg::MODE_CANCEL: begin
               s = find_slot(w.target_id);
               if (s < 0) ans.status = tte_pkg::STATUS_NOT_FOUND;
               else slot_used[s] = 1'b0;
            end
            tte_pkg::MODE_RESCHEDULE: begin
               // A missing or negative id is simply skipped by the cancel step.
               s = find_slot(w.target_id);
               if (s >= 0) slot_used[s] = 1'b0;
               ans.status = place_timer(w.now_time, w.delay, nid);
            end
            tte_pkg::MODE_QUERY: begin
               s = find_slot(w.target_id);
               if (s < 0) ans.status = tte_pkg::STATUS_NOT_FOUND;
               else ans.expired = w.now_time > slot_expiry[s];
            end
         endcase
         ans.new_timer_id = nid;
         foreach (slot_used[i]) begin
            if (slot_used[i]) begin
               if (!ans.armed || slot_expiry[i] < ans.earliest_expiry)
                  ans.earliest_expiry = slot_expiry[i];
               ans.armed = 1'b1;
               used++;
            end
         end
         // An expiry of zero is still reported as one.
         if (ans.armed && ans.earliest_expiry == 48'd0) ans.earliest_expiry = 48'd1;
         if (used > peak_used) peak_used = used;
         return ans;
      endfunction

      function void note_request(input tte_pkg::req_type w);
         tte_pkg::rsp_type ans;
         ans = compute_answer(w);
         mode_seen[w.mode]++;
         if (ans.status == tte_pkg::STATUS_TABLE_FULL) full_seen++;
         if (ans.status == tte_pkg::STATUS_NOT_FOUND) missing_seen++;
         if (ans.expired) expired_seen++;
         pending_answers.push_back(ans);
      endfunction

      function void check_response(input tte_pkg::rsp_type got);
         tte_pkg::rsp_type want;
         logic             bad;
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: answer with no request waiting: status %0d id %0d", $realtime,
                        got.status, got.new_timer_id);
            return;
         end
         want = pending_answers.pop_front();
         bad = (got.status !== want.status) || (got.new_timer_id !== want.new_timer_id) ||
               (got.expired !== want.expired) || (got.armed !== want.armed) ||
               (got.earliest_expiry !== want.earliest_expiry);
         if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: wrong answer, expected / actual:", $realtime);
               $display("   status %0d / %0d, new id %0d / %0d, expired %0b / %0b",
                        want.status, got.status, want.new_timer_id, got.new_timer_id,
                        want.expired, got.expired);
               $display("   armed %0b / %0b, earliest %0h / %0h", want.armed, got.armed,
                        want.earliest_expiry, got.earliest_expiry);
            end
         end
      endfunction

      function int outstanding();
         return pending_answers.size();
      endfunction

      // Answers still owed at the end count as failures too.
      function int failures();
         return mismatches + pending_answers.size();
      endfunction

      // Id of a random live timer, or -1 when the table is empty.
      function logic [31:0] pick_live_id();
         int live [$];
         foreach (slot_used[i]) begin
            if (slot_used[i]) live.push_back(i);
         end
         if (live.size() == 0) return '1;
         return {1'b0, slot_id[live[$urandom_range(0, live.size() - 1)]]};
      endfunction
   endclass

   // All block inputs start at known values; reset is held from time zero.
   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   tte_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   tte_pkg::rsp_type rsp_data;
   int               stall_cycles = 0;
   logic [47:0]      time_base = '0;

   timer_table_tracker tracker = new();

   always #5 clock = ~clock;

   timer_table_earliest_expiry_unit uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // Everything is sampled at the rising edge, before the edge's own updates land, so
   // the values seen here are the ones the block saw. An answer is checked before a
   // new word is noted, although busy keeps the two from ever sharing an edge.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) tracker.check_response(rsp_data);
      if (!reset && start && !busy) tracker.note_request(req_data);
      if (!reset && (rsp_strobe || (start && !busy))) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   // The watchdog ends a run that has gone quiet for too long.
   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
   end

   function automatic tte_pkg::req_type make_word(input logic [1:0] mode,
                                                  input logic [47:0] now,
                                                  input logic [31:0] dly,
                                                  input logic [31:0] id);
      tte_pkg::req_type w;
      w.mode      = mode;
      w.now_time  = now;
      w.delay     = dly;
      w.target_id = id;
      return w;
   endfunction

   // Offers one word and returns at the edge that accepts it. Unless quiet is set, the
   // sender first idles now and then for a random number of cycles, with junk on the
   // data lines. start is only ever assigned once in any time step.
   task automatic issue_word(input tte_pkg::req_type w, input bit quiet);
      logic [127:0] junk;
      if (!quiet && $urandom_range(0, 99) < 37) begin
         junk = {$urandom, $urandom, $urandom, $urandom};
         start    <= 1'b0;
         req_data <= junk[113:0];
         repeat ($urandom_range(1, 45)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
   endtask

   // Holds the sender off until every answer owed has come back.
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (tracker.outstanding() != 0);
   endtask

   // The fixed opening sequence. The ids assume a fresh counter after reset: the four
   // schedules hand out ids 0 to 3, the three reschedules ids 4 to 6.
   task automatic run_directed();
      // Requests against an empty table, including a none id and the top id.
      issue_word(make_word(tte_pkg::MODE_QUERY, 48'd0, 32'd0, 32'd0), 1'b0);
      issue_word(make_word(tte_pkg::MODE_CANCEL, 48'd0, 32'd0, 32'hFFFF_FFFF), 1'b0);
      issue_word(make_word(tte_pkg::MODE_CANCEL, 48'd0, 32'd0, 32'h7FFF_FFFF), 1'b0);
      // An expiry of zero, which must be reported as one.
      issue_word(make_word(tte_pkg::MODE_SCHEDULE, 48'd0, 32'd0, 32'd0), 1'b0);
      // Largest time plus largest delay saturates the expiry.
      issue_word(make_word(tte_pkg::MODE_SCHEDULE, '1, 32'h7FFF_FFFF, 32'd0), 1'b0);
      // Negative delays are treated as no delay at all.
      issue_word(make_word(tte_pkg::MODE_SCHEDULE, 48'd1000, 32'h8000_0000, 32'd0), 1'b0);
      issue_word(make_word(tte_pkg::MODE_SCHEDULE, 48'd1000, 32'hFFFF_FFFF, 32'd5), 1'b0);
      // Expiry means strictly later than the stored time.
      issue_word(make_word(tte_pkg::MODE_QUERY, 48'd0, 32'd0, 32'd0), 1'b0);
      issue_word(make_word(tte_pkg::MODE_QUERY, 48'd1, 32'd0, 32'd0), 1'b0);
      issue_word(make_word(tte_pkg::MODE_QUERY, '1, 32'd0, 32'd1), 1'b0);
      issue_word(make_word(tte_pkg::MODE_QUERY, 48'd1000, 32'd0, 32'd2), 1'b0);
      issue_word(make_word(tte_pkg::MODE_QUERY, 48'd1001, 32'd0, 32'd2), 1'b0);
      issue_word(make_word(tte_pkg::MODE_QUERY, 48'd5, 32'd0, 32'h8000_0000), 1'b0);
      // Reschedule of a live id, of the none id and of an id never handed out.
      issue_word(make_word(tte_pkg::MODE_RESCHEDULE, 48'd50, 32'd100, 32'd0), 1'b0);
      issue_word(make_word(tte_pkg::MODE_RESCHEDULE, 48'd2000, 32'd5, 32'hFFFF_FFFF),
                 1'b0);
      issue_word(make_word(tte_pkg::MODE_RESCHEDULE, 48'h8000_0000_0000, 32'h7FFF_FFFF,
                           32'd12345), 1'b0);
      // A cancel that hits, then the same cancel again on a missing id.
      issue_word(make_word(tte_pkg::MODE_CANCEL, 48'd0, 32'd0, 32'd4), 1'b0);
      issue_word(make_word(tte_pkg::MODE_CANCEL, 48'd0, 32'd0, 32'd4), 1'b0);
      issue_word(make_word(tte_pkg::MODE_QUERY, '1, 32'd0, 32'd6), 1'b0);
      // Empty the table again, so armed drops and the earliest expiry reads zero.
      issue_word(make_word(tte_pkg::MODE_CANCEL, 48'd0, 32'd0, 32'd1), 1'b0);
      issue_word(make_word(tte_pkg::MODE_CANCEL, 48'd0, 32'd0, 32'd2), 1'b0);
      issue_word(make_word(tte_pkg::MODE_CANCEL, 48'd0, 32'd0, 32'd3), 1'b0);
      issue_word(make_word(tte_pkg::MODE_CANCEL, 48'd0, 32'd0, 32'd5), 1'b0);
      issue_word(make_word(tte_pkg::MODE_CANCEL, 48'd0, 32'd0, 32'd6), 1'b0);
      issue_word(make_word(tte_pkg::MODE_QUERY, 48'd0, 32'd0, 32'd1), 1'b0);
   endtask

   // One random request word. Every block of a hundred words spends its first seventy
   // mostly scheduling, which fills the table and pushes it into the full case, and
   // the rest mostly cancelling. Ids are mostly those of live timers and times follow
   // a slowly advancing clock, so queries land on both sides of the expiry. A few
   // words are pure noise with every field drawn at random.
   function automatic tte_pkg::req_type random_word(input int n);
      tte_pkg::req_type w;
      int               roll;
      logic             fill;
      fill = (n % 100) < 70;
      if ($urandom_range(0, 99) < 12) begin
         w.mode      = 2'($urandom);
         w.now_time  = {16'($urandom), 32'($urandom)};
         w.delay     = $urandom;
         w.target_id = $urandom;
         return w;
      end
      roll = $urandom_range(0, 99);
      if (fill) begin
         w.mode = roll < 55 ? tte_pkg::MODE_SCHEDULE :
                  roll < 70 ? tte_pkg::MODE_RESCHEDULE :
                  roll < 85 ? tte_pkg::MODE_QUERY : tte_pkg::MODE_CANCEL;
      end else begin
         w.mode = roll < 20 ? tte_pkg::MODE_SCHEDULE :
                  roll < 30 ? tte_pkg::MODE_RESCHEDULE :
                  roll < 50 ? tte_pkg::MODE_QUERY : tte_pkg::MODE_CANCEL;
      end
      // Now and then the clock jumps, sometimes right up against the top of the range.
      roll = $urandom_range(0, 99);
      if (roll < 2) time_base = {16'($urandom), 32'($urandom)};
      else if (roll < 4) time_base = '1 - 48'($urandom_range(0, 2000));
      else time_base = time_base + 48'($urandom_range(0, 300));
      w.now_time = time_base;
      roll = $urandom_range(0, 99);
      if (roll < 60) w.delay = $urandom_range(0, 500);
      else if (roll < 70) w.delay = 0;
      else if (roll < 80) w.delay = {1'b1, 31'($urandom)};
      else w.delay = $urandom;
      roll = $urandom_range(0, 99);
      if (roll < 75) w.target_id = tracker.pick_live_id();
      else if (roll < 85) w.target_id = -1;
      else w.target_id = $urandom;
      return w;
   endfunction

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      wait_drained();

      // Words 200 to 299 go back to back with no idling, and at word 300 the sender
      // waits until the table has answered everything.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == 300) wait_drained();
         issue_word(random_word(n), n >= 200 && n < 300);
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d schedule, %0d cancel, %0d reschedule and %0d query words.",
               tracker.mode_seen[tte_pkg::MODE_SCHEDULE],
               tracker.mode_seen[tte_pkg::MODE_CANCEL],
               tracker.mode_seen[tte_pkg::MODE_RESCHEDULE],
               tracker.mode_seen[tte_pkg::MODE_QUERY]);
      $display("It saw %0d full-table and %0d missing-id answers, %0d expired timers, %0d %s",
               tracker.full_seen, tracker.missing_seen, tracker.expired_seen,
               tracker.peak_used, "timers live at most.");
      if (tracker.failures() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d wrong or missing answers", tracker.failures());
         $display("Verification failed");
      end
      $finish;
   end

endmodule
